FILE: sv/chunk_deframer_rc4_decrypt_top_defines.svh
// Assertion helpers used by the deframer top.
`ifndef CHUNK_DEFRAMER_RC4_DECRYPT_TOP_DEFINES_SVH
`define CHUNK_DEFRAMER_RC4_DECRYPT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CDRC4_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDRC4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cdrc4_pkg.sv
package cdrc4_pkg;

    localparam int KEY_BYTES_MAX_DEF = 16;
    localparam int CMDQ_DEPTH        = 4;
    localparam int CMDQ_AW           = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW           = $clog2(CMDQ_DEPTH + 1);
    localparam int OUT_DEPTH         = 2;
    localparam int OUT_AW            = $clog2(OUT_DEPTH);
    localparam int OUT_CW            = $clog2(OUT_DEPTH + 1);
    localparam int PERM_DEPTH        = 256;

    localparam logic [7:0] ESC_BYTE   = 8'hff;
    localparam logic [7:0] CHUNK_MARK = 8'h19;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    typedef enum logic [1:0] {
        REG_DECRYPT_ENABLE = 2'd0,
        REG_KEY_LOW        = 2'd1,
        REG_KEY_HIGH       = 2'd2,
        REG_KEY_LENGTH     = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_CRYPT = 2'd0,
        CMD_PLAIN = 2'd1,
        CMD_KEY   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic        chunk_end;
        logic        truncated;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        chunk_end;
        logic        truncated;
    } res_t;

    typedef struct packed {
        logic        decrypt_enable;
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [4:0]  key_length;
    } cfg_t;

    typedef struct packed {
        logic              idle;
        logic [OUT_CW-1:0] ocount;
    } back_stat_t;

    function automatic cmd_t make_cmd(cmd_kind_t kind, logic [7:0] data,
                                      logic chunk_end, logic truncated);
        cmd_t c;
        c.kind      = kind;
        c.data      = data;
        c.chunk_end = chunk_end;
        c.truncated = truncated;
        return c;
    endfunction

endpackage

FILE: sv/chunk_deframer_rc4_decrypt_top.sv
// Length-prefixed packet deframer with RC4 decryption. Push one packet byte
// per request, with packet_last on the final byte; pop payload bytes with
// chunk_end and truncated flags from the result side. A front parser strips
// prefixes and classifies each byte, hands requests through a four-entry queue
// to the cipher engine, which owns the 256-byte permutation memory and a
// two-entry result buffer. A decrypted byte goes through the engine in steps
// (read S[i], read S[j], write S[i] while reading the keystream entry, write
// S[j]); a pass-through byte or truncation notice goes straight to the result
// buffer. The front takes a byte per cycle while the queue has room for two
// requests. A key schedule request, and the key schedule after reset, occupy
// the engine while it refills the identity permutation and runs the swap steps;
// bytes pushed meanwhile wait in the queue. Write configuration only when idle.
`include "chunk_deframer_rc4_decrypt_top_defines.svh"

module chunk_deframer_rc4_decrypt_top #(
    parameter int KEY_BYTES_MAX = cdrc4_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    input  logic        packet_last,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  payload_byte,
    output logic        chunk_end,
    output logic        truncated,
    // configuration writes
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import cdrc4_pkg::*;

    cfg_t               cfg_reg;
    logic [1:0]         wr_cnt;
    cmd_t               wr0, wr1;
    cmd_t               q_head;
    logic [CMDQ_CW-1:0] q_count;
    logic               q_pop;
    back_stat_t         back_stat;

    // register file: hold each value until rewritten
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decrypt_enable <= 1'b0;
            cfg_reg.key_low        <= '0;
            cfg_reg.key_high       <= '0;
            cfg_reg.key_length     <= 5'd16;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_DECRYPT_ENABLE: cfg_reg.decrypt_enable <= cfg_data[0];
                REG_KEY_LOW:        cfg_reg.key_low        <= cfg_data;
                REG_KEY_HIGH:       cfg_reg.key_high       <= cfg_data;
                REG_KEY_LENGTH:     cfg_reg.key_length     <= cfg_data[4:0];
                default:            cfg_reg.key_length     <= cfg_reg.key_length;
            endcase
        end
    end

    // front: parse prefixes, drop stripped zeros, raise truncation notices
    cdrc4_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .data_byte      (data_byte),
        .packet_last    (packet_last),
        .decrypt_enable (cfg_reg.decrypt_enable),
        .q_count        (q_count),
        .wr_cnt         (wr_cnt),
        .wr0            (wr0),
        .wr1            (wr1)
    );

    // decoupling queue of requests
    cdrc4_cmdq u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_cnt (wr_cnt),
        .wr0    (wr0),
        .wr1    (wr1),
        .rd     (q_pop),
        .head   (q_head),
        .count  (q_count)
    );

    // back: RC4 engine, key schedule sequencer and result buffer
    cdrc4_back #(.KEY_BYTES_MAX(KEY_BYTES_MAX)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_head       (q_head),
        .q_empty      (q_count == '0),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .payload_byte (payload_byte),
        .chunk_end    (chunk_end),
        .truncated    (truncated),
        .stat         (back_stat)
    );

    `CDRC4_ASSERT_NOW(a_cmdq_bound, 1'b1, q_count <= CMDQ_CW'(CMDQ_DEPTH), "request queue overflow")
    `CDRC4_ASSERT_NOW(a_out_bound, 1'b1, back_stat.ocount <= OUT_CW'(OUT_DEPTH), "result buffer overflow")
    `CDRC4_ASSERT_NEXT(a_no_phantom, empty && q_count == '0 && back_stat.idle, empty, "result without request")
    `CDRC4_ASSERT_NOW(a_pop_idle, q_pop, back_stat.idle && q_count != '0, "request taken while engine busy")

endmodule

FILE: sv/cdrc4_ram.sv
module cdrc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read and write to the same address return the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/cdrc4_cmdq.sv
module cdrc4_cmdq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 wr_cnt,
    input  cdrc4_pkg::cmd_t            wr0,
    input  cdrc4_pkg::cmd_t            wr1,
    input  logic                       rd,
    output cdrc4_pkg::cmd_t            head,
    output logic [cdrc4_pkg::CMDQ_CW-1:0] count
);
    import cdrc4_pkg::*;

    cmd_t               mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wp_reg, rp_reg;
    logic [CMDQ_CW-1:0] count_reg;
    logic [CMDQ_AW-1:0] wp_plus1;

    assign wp_plus1 = wp_reg + CMDQ_AW'(1);
    assign head     = mem_reg[rp_reg];
    assign count    = count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem_reg[wp_reg] <= wr0;
        end
        if (wr_cnt == 2'd2)
        begin
            mem_reg[wp_plus1] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_reg + CMDQ_AW'(wr_cnt);
            rp_reg    <= rp_reg + CMDQ_AW'(rd);
            count_reg <= count_reg + CMDQ_CW'(wr_cnt) - CMDQ_CW'(rd);
        end
    end
endmodule

FILE: sv/cdrc4_front.sv
module cdrc4_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          operation,
    input  logic [7:0]                    data_byte,
    input  logic                          packet_last,
    input  logic                          decrypt_enable,
    input  logic [cdrc4_pkg::CMDQ_CW-1:0] q_count,
    output logic [1:0]                    wr_cnt,
    output cdrc4_pkg::cmd_t               wr0,
    output cdrc4_pkg::cmd_t               wr1
);
    import cdrc4_pkg::*;

    typedef enum logic [7:0] {
        PH_FIRST  = 8'b0000_0001,
        PH_SECOND = 8'b0000_0010,
        PH_WHOLE  = 8'b0000_0100,
        PH_PREFIX = 8'b0000_1000,
        PH_FF     = 8'b0001_0000,
        PH_FFFF   = 8'b0010_0000,
        PH_LEN    = 8'b0100_0000,
        PH_BODY   = 8'b1000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [31:0] rem_reg, rem_next;
    logic [2:0]  left_reg, left_next;
    logic        first_reg, first_next;

    logic        accept;
    logic        body_go;
    logic [31:0] body_rem;
    logic        body_first;
    logic [31:0] rem_dec;
    logic [31:0] len_shift;
    logic [2:0]  left_dec;
    logic        strip;
    cmd_t        notice;

    // take an item only with room for the two requests it may make
    assign full   = q_count > CMDQ_CW'(CMDQ_DEPTH - 2);
    assign accept = push && !full;
    assign notice = make_cmd(CMD_PLAIN, ZERO_BYTE, 1'b0, 1'b1);
    assign rem_dec   = body_rem - 32'd1;
    assign len_shift = {rem_reg[23:0], data_byte};
    assign left_dec  = (left_reg != 3'd0) ? left_reg - 3'd1 : left_reg;
    assign strip     = body_first && decrypt_enable && (body_rem > 32'd1)
                       && (data_byte == ZERO_BYTE);

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        rem_next   = rem_reg;
        left_next  = left_reg;
        first_next = first_reg;
        wr_cnt     = 2'd0;
        wr0        = make_cmd(CMD_CRYPT, data_byte, packet_last, 1'b0);
        wr1        = make_cmd(CMD_CRYPT, data_byte, packet_last, 1'b0);
        body_go    = 1'b0;
        body_rem   = rem_reg;
        body_first = first_reg;
        if (accept && operation)
        begin
            wr_cnt = 2'd1;
            wr0    = make_cmd(CMD_KEY, ZERO_BYTE, 1'b0, 1'b0);
        end
        else if (accept)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    if (packet_last)
                    begin
                        wr_cnt = 2'd1;
                        wr0    = make_cmd(CMD_CRYPT, data_byte, 1'b1, 1'b0);
                    end
                    else
                    begin
                        held_next  = data_byte;
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    if (held_reg == ZERO_BYTE && data_byte == CHUNK_MARK)
                    begin
                        phase_next = PH_PREFIX;
                    end
                    else
                    begin
                        phase_next = PH_WHOLE;
                        // drop a leading zero ahead of a zero when decrypting
                        if (decrypt_enable && held_reg == ZERO_BYTE
                            && data_byte == ZERO_BYTE)
                        begin
                            wr_cnt = 2'd1;
                        end
                        else
                        begin
                            wr_cnt = 2'd2;
                            wr0    = make_cmd(CMD_CRYPT, held_reg, 1'b0, 1'b0);
                        end
                    end
                end
                PH_WHOLE:
                begin
                    wr_cnt = 2'd1;
                end
                PH_PREFIX:
                begin
                    if (data_byte == ESC_BYTE)
                    begin
                        phase_next = PH_FF;
                    end
                    else if (data_byte != ZERO_BYTE)
                    begin
                        rem_next   = {24'd0, data_byte};
                        first_next = 1'b1;
                        phase_next = PH_BODY;
                    end
                    if (packet_last && data_byte != ZERO_BYTE)
                    begin
                        wr_cnt = 2'd1;
                        wr0    = notice;
                    end
                end
                PH_FF:
                begin
                    if (data_byte == ZERO_BYTE)
                    begin
                        phase_next = PH_BODY;
                        body_go    = 1'b1;
                        body_rem   = 32'd255;
                        body_first = 1'b1;
                    end
                    else
                    begin
                        if (data_byte == ESC_BYTE)
                        begin
                            phase_next = PH_FFFF;
                        end
                        else
                        begin
                            left_next  = 3'd2;
                            rem_next   = 32'd0;
                            phase_next = PH_LEN;
                        end
                        if (packet_last)
                        begin
                            wr_cnt = 2'd1;
                            wr0    = notice;
                        end
                    end
                end
                PH_FFFF:
                begin
                    if (data_byte == ESC_BYTE)
                    begin
                        left_next = 3'd4;
                        rem_next  = 32'd0;
                    end
                    else
                    begin
                        left_next = 3'd1;
                        rem_next  = {24'd0, data_byte};
                    end
                    phase_next = PH_LEN;
                    if (packet_last)
                    begin
                        wr_cnt = 2'd1;
                        wr0    = notice;
                    end
                end
                PH_LEN:
                begin
                    rem_next  = len_shift;
                    left_next = left_dec;
                    if (left_dec == 3'd0 && len_shift == 32'd0)
                    begin
                        phase_next = PH_PREFIX;
                    end
                    else
                    begin
                        if (left_dec == 3'd0)
                        begin
                            first_next = 1'b1;
                            phase_next = PH_BODY;
                        end
                        if (packet_last)
                        begin
                            wr_cnt = 2'd1;
                            wr0    = notice;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (rem_reg == 32'd0)
                    begin
                        phase_next = PH_PREFIX;
                    end
                    else
                    begin
                        body_go = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase

            if (body_go)
            begin
                first_next = 1'b0;
                rem_next   = rem_dec;
                if (strip)
                begin
                    if (packet_last)
                    begin
                        wr_cnt = 2'd1;
                        wr0    = notice;
                    end
                end
                else
                begin
                    if (rem_dec == 32'd0)
                    begin
                        phase_next = PH_PREFIX;
                    end
                    wr_cnt = 2'd1;
                    wr0    = make_cmd(CMD_CRYPT, data_byte,
                                      (rem_dec == 32'd0) || packet_last,
                                      packet_last && (rem_dec != 32'd0));
                end
            end

            if (packet_last)
            begin
                phase_next = PH_FIRST;
                rem_next   = 32'd0;
                left_next  = 3'd0;
                first_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            held_reg  <= '0;
            rem_reg   <= '0;
            left_reg  <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            rem_reg   <= rem_next;
            left_reg  <= left_next;
            first_reg <= first_next;
        end
    end
endmodule

FILE: sv/cdrc4_back.sv
module cdrc4_back #(
    parameter int KEY_BYTES_MAX = cdrc4_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cdrc4_pkg::cfg_t      cfg,
    input  cdrc4_pkg::cmd_t      q_head,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           payload_byte,
    output logic                 chunk_end,
    output logic                 truncated,
    output cdrc4_pkg::back_stat_t stat
);
    import cdrc4_pkg::*;

    localparam int KIDX_W = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam logic [4:0] KEY_MAX = 5'(KEY_BYTES_MAX);

    typedef enum logic [8:0] {
        B_IDLE = 9'b0_0000_0001,
        B_FILL = 9'b0_0000_0010,
        B_K1   = 9'b0_0000_0100,
        B_K2   = 9'b0_0000_1000,
        B_K3   = 9'b0_0001_0000,
        B_K4   = 9'b0_0010_0000,
        B_C2   = 9'b0_0100_0000,
        B_C3   = 9'b0_1000_0000,
        B_C4   = 9'b1_0000_0000
    } bstate_t;

    bstate_t             state_reg, state_next;
    logic [7:0]          k_reg, k_next;
    logic [KIDX_W-1:0]   kidx_reg, kidx_next;
    logic [7:0]          i_reg, i_next;
    logic [7:0]          j_reg, j_next;
    logic [7:0]          si_reg, si_next;
    logic [7:0]          sj_reg, sj_next;
    cmd_t                cmd_reg, cmd_next;
    res_t                ofifo_reg [OUT_DEPTH];
    logic [OUT_AW-1:0]   owp_reg, orp_reg;
    logic [OUT_CW-1:0]   ocount_reg;

    logic                ram_we;
    logic [7:0]          ram_waddr, ram_wdata, ram_raddr, ram_rdata;
    logic                res_push;
    res_t                res;
    logic                res_pop;
    logic [7:0]          key_bytes [KEY_BYTES_MAX];
    logic [4:0]          key_last;
    logic [7:0]          ks_idx;
    logic [7:0]          keystream;

    cdrc4_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    for (genvar g = 0; g < KEY_BYTES_MAX; g++)
    begin : g_key
        if (g < 8)
        begin : g_low
            assign key_bytes[g] = cfg.key_low[8*g +: 8];
        end
        else
        begin : g_high
            assign key_bytes[g] = cfg.key_high[8*(g-8) +: 8];
        end
    end

    // clamp the key length into 1..KEY_BYTES_MAX, held as last index
    assign key_last = (cfg.key_length == 5'd0)   ? 5'd0 :
                      (cfg.key_length > KEY_MAX) ? KEY_MAX - 5'd1 :
                                                   cfg.key_length - 5'd1;

    // swap already done in the same step: bypass the two fresh entries
    assign ks_idx    = si_reg + sj_reg;
    assign keystream = (ks_idx == j_reg) ? si_reg :
                       (ks_idx == i_reg) ? sj_reg : ram_rdata;

    assign res_pop      = pop && (ocount_reg != '0);
    assign empty        = (ocount_reg == '0);
    assign payload_byte = ofifo_reg[orp_reg].data;
    assign chunk_end    = ofifo_reg[orp_reg].chunk_end;
    assign truncated    = ofifo_reg[orp_reg].truncated;
    assign stat.idle    = (state_reg == B_IDLE);
    assign stat.ocount  = ocount_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        kidx_next  = kidx_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        cmd_next   = cmd_reg;
        ram_we     = 1'b0;
        ram_waddr  = k_reg;
        ram_wdata  = k_reg;
        ram_raddr  = k_reg;
        q_pop      = 1'b0;
        res_push   = 1'b0;
        res.data      = q_head.data;
        res.chunk_end = q_head.chunk_end;
        res.truncated = q_head.truncated;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && ocount_reg < OUT_CW'(OUT_DEPTH))
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        CMD_KEY:
                        begin
                            k_next     = '0;
                            state_next = B_FILL;
                        end
                        CMD_CRYPT:
                        begin
                            if (cfg.decrypt_enable)
                            begin
                                cmd_next   = q_head;
                                i_next     = i_reg + 8'd1;
                                ram_raddr  = i_reg + 8'd1;
                                state_next = B_C2;
                            end
                            else
                            begin
                                res_push = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            B_FILL:
            begin
                ram_we = 1'b1;
                k_next = k_reg + 8'd1;
                if (k_reg == 8'hff)
                begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = B_K1;
                end
            end
            B_K1:
            begin
                state_next = B_K2;
            end
            B_K2:
            begin
                si_next    = ram_rdata;
                j_next     = j_reg + ram_rdata + key_bytes[kidx_reg];
                ram_raddr  = j_reg + ram_rdata + key_bytes[kidx_reg];
                state_next = B_K3;
            end
            B_K3:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                state_next = B_K4;
            end
            B_K4:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                k_next    = k_reg + 8'd1;
                kidx_next = (5'(kidx_reg) == key_last) ? '0 : kidx_reg + KIDX_W'(1);
                if (k_reg == 8'hff)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = B_IDLE;
                end
                else
                begin
                    state_next = B_K1;
                end
            end
            B_C2:
            begin
                si_next    = ram_rdata;
                j_next     = j_reg + ram_rdata;
                ram_raddr  = j_reg + ram_rdata;
                state_next = B_C3;
            end
            B_C3:
            begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = ram_rdata;
                sj_next    = ram_rdata;
                ram_raddr  = si_reg + ram_rdata;
                state_next = B_C4;
            end
            B_C4:
            begin
                ram_we        = 1'b1;
                ram_waddr     = j_reg;
                ram_wdata     = si_reg;
                res_push      = 1'b1;
                res.data      = cmd_reg.data ^ keystream;
                res.chunk_end = cmd_reg.chunk_end;
                res.truncated = cmd_reg.truncated;
                state_next    = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        si_reg  <= si_next;
        sj_reg  <= sj_next;
        cmd_reg <= cmd_next;
        if (res_push)
        begin
            ofifo_reg[owp_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_FILL;
            k_reg      <= '0;
            kidx_reg   <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            owp_reg    <= '0;
            orp_reg    <= '0;
            ocount_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            kidx_reg   <= kidx_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            owp_reg    <= owp_reg + OUT_AW'(res_push);
            orp_reg    <= orp_reg + OUT_AW'(res_pop);
            ocount_reg <= ocount_reg + OUT_CW'(res_push) - OUT_CW'(res_pop);
        end
    end
endmodule

FILE: sim/deframer_checker.sv
`timescale 1ns / 1ps

module deframer_checker
    import cdrc4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    input  logic        packet_last,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  payload_byte,
    input  logic        chunk_end,
    input  logic        truncated,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    typedef enum logic [3:0] {
        PH_FIRST, PH_SECOND, PH_WHOLE, PH_PREFIX, PH_FF, PH_FFFF, PH_LEN, PH_BODY
    } phase_t;

    cfg_t        cfg;
    logic [7:0]  sbox [256];
    logic [7:0]  ci, cj;
    phase_t      phase;
    logic [7:0]  held;
    logic [31:0] remain;
    logic [2:0]  len_left;
    logic        first_chunk;
    res_t        expected_q [$];

    assign pending = expected_q.size();

    task automatic key_schedule();
        logic [7:0] key [16];
        logic [7:0] j, t;
        int n;
        for (int k = 0; k < 8; k++)
        begin
            key[k]     = cfg.key_low[8*k +: 8];
            key[k + 8] = cfg.key_high[8*k +: 8];
        end
        n = cfg.key_length;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        for (int k = 0; k < 256; k++) sbox[k] = k[7:0];
        j = 0;
        for (int k = 0; k < 256; k++)
        begin
            j = j + sbox[k] + key[k % n];
            t = sbox[k]; sbox[k] = sbox[j]; sbox[j] = t;
        end
        ci = 0;
        cj = 0;
    endtask

    function automatic logic [7:0] decrypt(logic [7:0] b);
        logic [7:0] t;
        if (!cfg.decrypt_enable) return b;
        ci = ci + 1;
        cj = cj + sbox[ci];
        t = sbox[ci]; sbox[ci] = sbox[cj]; sbox[cj] = t;
        t = sbox[ci] + sbox[cj];
        return b ^ sbox[t];
    endfunction

    task automatic expect_byte(logic [7:0] b, logic e, logic tr);
        res_t r;
        r.data = b; r.chunk_end = e; r.truncated = tr;
        expected_q.push_back(r);
    endtask

    task automatic chunk_byte(logic [7:0] b, logic last);
        logic strip;
        strip = first_chunk && cfg.decrypt_enable && remain > 1 && b == ZERO_BYTE;
        first_chunk = 0;
        remain = remain - 1;
        if (strip)
        begin
            if (last) expect_byte(0, 0, 1);
            return;
        end
        if (remain == 0) phase = PH_PREFIX;
        expect_byte(decrypt(b), remain == 0 || last, last && remain != 0);
    endtask

    // advance the deframer prediction by one request
    task automatic predict_request(logic op, logic [7:0] b, logic last);
        if (op)
        begin
            key_schedule();
            return;
        end
        case (phase)
            PH_FIRST:
                if (last) expect_byte(decrypt(b), 1, 0);
                else
                begin
                    held = b;
                    phase = PH_SECOND;
                end
            PH_SECOND:
                if (held == ZERO_BYTE && b == CHUNK_MARK) phase = PH_PREFIX;
                else
                begin
                    if (!(cfg.decrypt_enable && held == ZERO_BYTE && b == ZERO_BYTE))
                        expect_byte(decrypt(held), 0, 0);
                    expect_byte(decrypt(b), last, 0);
                    phase = PH_WHOLE;
                end
            PH_WHOLE:
                expect_byte(decrypt(b), last, 0);
            PH_PREFIX:
            begin
                if (b == ESC_BYTE) phase = PH_FF;
                else if (b != ZERO_BYTE)
                begin
                    remain = b;
                    first_chunk = 1;
                    phase = PH_BODY;
                end
                if (last && b != ZERO_BYTE) expect_byte(0, 0, 1);
            end
            PH_FF:
                if (b == ZERO_BYTE)
                begin
                    remain = 255;
                    first_chunk = 1;
                    phase = PH_BODY;
                    chunk_byte(b, last);
                end
                else
                begin
                    if (b == ESC_BYTE) phase = PH_FFFF;
                    else
                    begin
                        len_left = 2;
                        remain = 0;
                        phase = PH_LEN;
                    end
                    if (last) expect_byte(0, 0, 1);
                end
            PH_FFFF:
            begin
                if (b == ESC_BYTE)
                begin
                    len_left = 4;
                    remain = 0;
                end
                else
                begin
                    len_left = 1;
                    remain = b;
                end
                phase = PH_LEN;
                if (last) expect_byte(0, 0, 1);
            end
            PH_LEN:
            begin
                remain = {remain[23:0], b};
                if (len_left > 0) len_left = len_left - 1;
                if (len_left == 0)
                begin
                    if (remain == 0) phase = PH_PREFIX;
                    else
                    begin
                        first_chunk = 1;
                        phase = PH_BODY;
                    end
                end
                if (last && phase != PH_PREFIX) expect_byte(0, 0, 1);
            end
            PH_BODY:
                if (remain == 0) phase = PH_PREFIX;
                else chunk_byte(b, last);
            default:
                phase = PH_FIRST;
        endcase
        if (last)
        begin
            phase = PH_FIRST;
            remain = 0;
            len_left = 0;
            first_chunk = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        int   errs;
        errs = 0;
        if (!rst_n)
        begin
            cfg.decrypt_enable = 0;
            cfg.key_low = 0;
            cfg.key_high = 0;
            cfg.key_length = 16;
            key_schedule();
            phase = PH_FIRST;
            held = 0;
            remain = 0;
            len_left = 0;
            first_chunk = 0;
            expected_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_write)
                case (reg_index_t'(cfg_index))
                    REG_DECRYPT_ENABLE: cfg.decrypt_enable = cfg_data[0];
                    REG_KEY_LOW:        cfg.key_low = cfg_data;
                    REG_KEY_HIGH:       cfg.key_high = cfg_data;
                    REG_KEY_LENGTH:     cfg.key_length = cfg_data[4:0];
                    default:            cfg.key_length = cfg.key_length;
                endcase
            if (push && !full) predict_request(operation, data_byte, packet_last);
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: payload_byte %0h", payload_byte);
                    errs++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (payload_byte !== want.data)
                    begin
                        $error("payload_byte expected %0h actual %0h", want.data, payload_byte);
                        errs++;
                    end
                    if (chunk_end !== want.chunk_end)
                    begin
                        $error("chunk_end expected %0b actual %0b", want.chunk_end, chunk_end);
                        errs++;
                    end
                    if (truncated !== want.truncated)
                    begin
                        $error("truncated expected %0b actual %0b", want.truncated, truncated);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cdrc4_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    logic        operation = 0;
    logic [7:0]  data_byte = 0;
    logic        packet_last = 0;
    logic        empty;
    logic        pop = 0;
    logic [7:0]  payload_byte;
    logic        chunk_end;
    logic        truncated;
    logic        cfg_write = 0;
    logic [1:0]  cfg_index = 0;
    logic [63:0] cfg_data = 0;
    int          fail_count;
    int          pending;
    int          cycle = 0;
    // idle percentage for both sides; zero during the third random phase
    int          idle_pct = 35;
    logic        done = 0;

    localparam int CYCLE_LIMIT = 600000;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    chunk_deframer_rc4_decrypt_top i_dut (.*);

    deframer_checker i_checker (.*);

    // Drain results, stalling at random.
    always @(posedge clk)
        pop <= ($urandom_range(99) >= idle_pct);

    // Abort a run that hangs.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT && !done)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Send one request and hold it until accepted; drop push only if idling follows.
    task automatic send(logic op, logic [7:0] b, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        operation <= op;
        data_byte <= b;
        packet_last <= last;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic send_packet(logic [7:0] bytes [$]);
        foreach (bytes[k]) send(0, bytes[k], k == bytes.size() - 1);
    endtask

    // Wait for every expected result to drain, then let the engine settle.
    task automatic quiesce();
        push <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (1400) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [63:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 0;
    endtask

    // Build a chunked packet with random chunk lengths and prefix forms.
    function automatic void chunked_packet(ref logic [7:0] p [$]);
        int nchunks;
        int len;
        int form;
        p = '{ZERO_BYTE, CHUNK_MARK};
        nchunks = $urandom_range(3);
        for (int c = 0; c < nchunks; c++)
        begin
            form = $urandom_range(9);
            len = $urandom_range(12);
            if (form == 0)
            begin
                len = 255;
                p.push_back(ESC_BYTE);
            end
            else if (form == 1)
            begin
                p.push_back(ESC_BYTE); p.push_back($urandom_range(1, 254));
                p.push_back(len >> 8); p.push_back(len[7:0]);
            end
            else if (form == 2)
            begin
                p.push_back(ESC_BYTE); p.push_back(ESC_BYTE); p.push_back(ESC_BYTE);
                for (int s = 24; s >= 0; s -= 8) p.push_back(len >> s);
            end
            else if (len == 0 && $urandom_range(1)) p.push_back(ZERO_BYTE);
            else
            begin
                if (len == 0) len = 1;
                p.push_back(len);
            end
            for (int k = 0; k < len; k++)
                if (form == 0 && k == 0) p.push_back(ZERO_BYTE);
                else p.push_back($urandom_range(4) == 0 ? 8'h00 : $urandom_range(255));
        end
        // cut short now and then to hit truncation paths
        if ($urandom_range(4) == 0 && p.size() > 3)
            p = p[0:$urandom_range(2, p.size() - 1)];
    endfunction

    initial
    begin
        logic [7:0] pkt [$];
        int sent;
        int rnd;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        while (pending != 0 || full) @(posedge clk);

        // directed: cleartext forms
        send_packet('{8'hff});
        send_packet('{8'h00, 8'h00, 8'h5a});
        send_packet('{8'h00, 8'h19});
        send_packet('{8'h00, 8'h19, 8'h00, 8'h02, 8'haa, 8'h55});
        send_packet('{8'h00, 8'h19, 8'h03, 8'h01});
        send_packet('{8'h00, 8'h19, 8'hff});
        send_packet('{8'h00, 8'h19, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h01, 8'h77});
        send_packet('{8'h00, 8'h19, 8'hff, 8'h07, 8'h00, 8'h02, 8'h11, 8'h22});
        send(1, 8'h00, 0);
        quiesce();

        // decryption on, key low and key length registers at extremes
        write_reg(REG_DECRYPT_ENABLE, 64'd1);
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, 64'h0123456789abcdef);
        write_reg(REG_KEY_LENGTH, 64'd0);
        send(1, 8'h00, 0);
        send_packet('{8'h00, 8'h00, 8'h31, 8'h32});
        send_packet('{8'h00});
        send_packet('{8'h00, 8'h19, 8'h03, 8'h00, 8'h41, 8'h42});
        send_packet('{8'h00, 8'h19, 8'h03, 8'h00});
        send_packet('{8'h00, 8'h19, 8'hff, 8'h00, 8'h10});
        quiesce();

        // random phases through several key settings
        sent = 0;
        for (int phase_no = 0; phase_no < 6; phase_no++)
        begin
            write_reg(REG_DECRYPT_ENABLE, phase_no % 3 != 0);
            write_reg(REG_KEY_LOW, {$urandom, $urandom});
            write_reg(REG_KEY_HIGH, {$urandom, $urandom});
            write_reg(REG_KEY_LENGTH, phase_no == 1 ? 64'd31 : $urandom_range(1, 16));
            send(1, 8'h00, 0);
            idle_pct = (phase_no == 2) ? 0 : 35;
            while (sent < 260 * (phase_no + 1))
            begin
                rnd = $urandom_range(19);
                if (rnd == 0) send(1, $urandom, $urandom);
                else
                begin
                    if (rnd < 14) chunked_packet(pkt);
                    else
                    begin
                        pkt = {};
                        repeat ($urandom_range(1, 8)) pkt.push_back($urandom);
                        if (rnd == 14) pkt[0] = ZERO_BYTE;
                    end
                    send_packet(pkt);
                    sent += pkt.size();
                end
            end
            quiesce();
        end
        idle_pct = 35;

        done = 1;
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/cdrc4_pkg.sv
sv/cdrc4_ram.sv
sv/cdrc4_cmdq.sv
sv/cdrc4_front.sv
sv/cdrc4_back.sv
sv/chunk_deframer_rc4_decrypt_top.sv
sim/deframer_checker.sv
sim/testbench.sv
